[design/isl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isl_pkg
// Shared types for the interval set subtract and lookup block.
// ----------------------------------------------------------------------------
package isl_pkg;

   typedef enum logic [1:0] {
      CMD_CLEAR    = 2'd0,
      CMD_APPEND   = 2'd1,
      CMD_SUBTRACT = 2'd2,
      CMD_LOOKUP   = 2'd3
   } cmd_type;

   typedef struct packed {
      logic        found;
      logic [31:0] range_start;
      logic [31:0] range_end;
      logic [5:0]  entries_now;
      logic        overflow;
   } result_type;

   typedef struct packed {
      logic idle;
      logic done;
   } status_type;

endpackage

[design/isl_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isl_mem
// Range table storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module isl_mem #(
   parameter int DEPTH  = 32,
   parameter int DATA_W = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);
   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[design/isl_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isl_ctrl
// Command sequencer: scan, shift, cut and binary search over the range table.
// ----------------------------------------------------------------------------
module isl_ctrl #(
   parameter int MAX_RANGES  = 32,
   parameter int FRAME_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  isl_pkg::cmd_type              cmd,
   input  logic [31:0]                   frame_a,
   input  logic [31:0]                   frame_b,
   output isl_pkg::status_type           status,
   output isl_pkg::result_type           result,
   output logic                          mem_wr_en,
   output logic [$clog2(MAX_RANGES)-1:0] mem_wr_addr,
   output logic [2*FRAME_WIDTH-1:0]      mem_wr_data,
   output logic [$clog2(MAX_RANGES)-1:0] mem_rd_addr,
   input  logic [2*FRAME_WIDTH-1:0]      mem_rd_data
);
   import isl_pkg::*;

   localparam int FW    = FRAME_WIDTH;
   localparam int IDX_W = $clog2(MAX_RANGES);
   localparam int CNT_W = $clog2(MAX_RANGES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RANGES);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
   localparam logic [FW-1:0]    FR_ONE  = FW'(1);

   typedef enum logic [11:0] {
      S_IDLE    = 12'b0000_0000_0001,
      S_SCAN    = 12'b0000_0000_0010,
      S_EVAL    = 12'b0000_0000_0100,
      S_UP_RD   = 12'b0000_0000_1000,
      S_UP_WR   = 12'b0000_0001_0000,
      S_UP_PUT  = 12'b0000_0010_0000,
      S_HOLD    = 12'b0000_0100_0000,
      S_DN_RD   = 12'b0000_1000_0000,
      S_DN_WR   = 12'b0001_0000_0000,
      S_LK      = 12'b0010_0000_0000,
      S_LK_EVAL = 12'b0100_0000_0000,
      S_DONE    = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;
   logic signed [FW-1:0] a_ff, a_in, b_ff, b_in;
   logic signed [FW-1:0] s_ff, s_in, hold_e_ff, hold_e_in;
   logic signed [FW-1:0] up_s_ff, up_s_in, up_e_ff, up_e_in;
   logic signed [FW-1:0] rs_ff, rs_in, re_ff, re_in;
   logic split_ff, split_in, ret_done_ff, ret_done_in;
   logic ovf_ff, ovf_in, found_ff, found_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, i_ff, i_in, j_ff, j_in, pos_ff, pos_in;
   logic signed [CNT_W:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;

   logic signed [FW+31:0] a_wide, b_wide, rs_wide, re_wide;
   logic signed [FW-1:0]  req_a, req_b, rd_s, rd_e, dec_a, inc_b, new_s, new_e;
   logic signed [CNT_W+1:0] lk_sum;
   logic [CNT_W+5:0] cnt_wide;
   logic [CNT_W-1:0] i_dec, j_dec, j_inc, pos_inc;

   assign a_wide  = (FW + 32)'(signed'(frame_a));
   assign b_wide  = (FW + 32)'(signed'(frame_b));
   assign req_a   = a_wide[FW-1:0];
   assign req_b   = b_wide[FW-1:0];
   assign rd_s    = mem_rd_data[2*FW-1:FW];
   assign rd_e    = mem_rd_data[FW-1:0];
   assign dec_a   = a_ff - FR_ONE;
   assign inc_b   = b_ff + FR_ONE;
   assign new_s   = (rd_s < a_ff) ? rd_s : inc_b;
   assign new_e   = (rd_s < a_ff) ? dec_a : rd_e;
   assign lk_sum  = (CNT_W + 2)'(lo_ff) + (CNT_W + 2)'(hi_ff);
   assign i_dec   = i_ff - CNT_ONE;
   assign j_dec   = j_ff - CNT_ONE;
   assign j_inc   = j_ff + CNT_ONE;
   assign pos_inc = pos_ff + CNT_ONE;

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      s_in        = s_ff;
      hold_e_in   = hold_e_ff;
      up_s_in     = up_s_ff;
      up_e_in     = up_e_ff;
      rs_in       = rs_ff;
      re_in       = re_ff;
      split_in    = split_ff;
      ret_done_in = ret_done_ff;
      ovf_in      = ovf_ff;
      found_in    = found_ff;
      cnt_in      = cnt_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      pos_in      = pos_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = i_ff[IDX_W-1:0];
      mem_wr_data = {s_ff, hold_e_ff};
      mem_rd_addr = i_ff[IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in   = cmd;
               a_in     = req_a;
               b_in     = req_b;
               ovf_in   = 1'b0;
               found_in = 1'b0;
               rs_in    = '0;
               re_in    = '0;
               state_in = S_DONE;
               case (cmd)
                  CMD_CLEAR: cnt_in = '0;
                  CMD_APPEND: begin
                     if (cnt_ff >= CNT_MAX) begin
                        ovf_in = 1'b1;
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = cnt_ff[IDX_W-1:0];
                        mem_wr_data = {req_a, req_b};
                        cnt_in      = cnt_ff + CNT_ONE;
                     end
                  end
                  CMD_SUBTRACT: begin
                     split_in = req_b < req_a;
                     i_in     = cnt_ff;
                     state_in = S_SCAN;
                  end
                  default: begin
                     rs_in    = req_a;
                     re_in    = req_a;
                     lo_in    = '0;
                     hi_in    = signed'({1'b0, cnt_ff}) - signed'((CNT_W + 1)'(1));
                     state_in = S_LK;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (i_ff == '0) begin
               state_in = S_DONE;
            end else begin
               i_in        = i_dec;
               mem_rd_addr = i_dec[IDX_W-1:0];
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            pos_in      = i_ff;
            s_in        = rd_s;
            ret_done_in = 1'b0;
            j_in        = i_ff;
            up_e_in     = rd_e;
            state_in    = S_SCAN;
            if (split_ff) begin
               if (rd_s == a_ff || rd_e < a_ff) begin
                  state_in = S_DONE;
               end else if (rd_s < a_ff) begin
                  hold_e_in = dec_a;
                  up_s_in   = a_ff;
                  state_in  = S_UP_RD;
                  j_in      = cnt_ff;
                  if (!(rd_e > a_ff)) begin
                     state_in = S_HOLD;
                  end else if (cnt_ff >= CNT_MAX) begin
                     ovf_in   = 1'b1;
                     state_in = S_HOLD;
                  end
               end
            end else if (rd_e < a_ff || rd_s > b_ff) begin
               state_in = S_SCAN;
            end else if (rd_s < a_ff && rd_e > b_ff) begin
               hold_e_in = dec_a;
               up_s_in   = inc_b;
               state_in  = S_UP_RD;
               j_in      = cnt_ff;
               if (!(rd_e > inc_b)) begin
                  state_in = S_HOLD;
               end else if (cnt_ff >= CNT_MAX) begin
                  ovf_in   = 1'b1;
                  state_in = S_HOLD;
               end
            end else if ((rd_s >= a_ff && rd_e <= b_ff) || new_e <= new_s) begin
               state_in = S_DN_RD;
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_data = {new_s, new_e};
            end
         end
         // open a slot at pos+1 by moving the tail up one entry at a time
         S_UP_RD: begin
            if (j_ff > pos_inc) begin
               mem_rd_addr = j_dec[IDX_W-1:0];
               state_in    = S_UP_WR;
            end else begin
               state_in = S_UP_PUT;
            end
         end
         S_UP_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = j_ff[IDX_W-1:0];
            mem_wr_data = mem_rd_data;
            j_in        = j_dec;
            state_in    = S_UP_RD;
         end
         S_UP_PUT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = pos_inc[IDX_W-1:0];
            mem_wr_data = {up_s_ff, up_e_ff};
            cnt_in      = cnt_ff + CNT_ONE;
            state_in    = S_HOLD;
         end
         S_HOLD: begin
            if (hold_e_ff <= s_ff) begin
               j_in        = pos_ff;
               ret_done_in = 1'b1;
               state_in    = S_DN_RD;
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = pos_ff[IDX_W-1:0];
               mem_wr_data = {s_ff, hold_e_ff};
               state_in    = S_DONE;
            end
         end
         // close the gap at j by moving the tail down one entry at a time
         S_DN_RD: begin
            if (j_inc < cnt_ff) begin
               mem_rd_addr = j_inc[IDX_W-1:0];
               state_in    = S_DN_WR;
            end else begin
               cnt_in   = cnt_ff - CNT_ONE;
               state_in = ret_done_ff ? S_DONE : S_SCAN;
            end
         end
         S_DN_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = j_ff[IDX_W-1:0];
            mem_wr_data = mem_rd_data;
            j_in        = j_inc;
            state_in    = S_DN_RD;
         end
         S_LK: begin
            if (lo_ff > hi_ff) begin
               state_in = S_DONE;
            end else begin
               mid_in      = lk_sum[CNT_W+1:1];
               mem_rd_addr = lk_sum[IDX_W:1];
               state_in    = S_LK_EVAL;
            end
         end
         S_LK_EVAL: begin
            state_in = S_LK;
            if (rd_s > a_ff) begin
               hi_in = mid_ff - signed'((CNT_W + 1)'(1));
            end else if (rd_e < a_ff) begin
               lo_in = mid_ff + signed'((CNT_W + 1)'(1));
            end else begin
               found_in = 1'b1;
               rs_in    = rd_s;
               re_in    = rd_e;
               state_in = S_DONE;
            end
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      cmd_ff      <= cmd_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      s_ff        <= s_in;
      hold_e_ff   <= hold_e_in;
      up_s_ff     <= up_s_in;
      up_e_ff     <= up_e_in;
      rs_ff       <= rs_in;
      re_ff       <= re_in;
      split_ff    <= split_in;
      ret_done_ff <= ret_done_in;
      ovf_ff      <= ovf_in;
      found_ff    <= found_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      pos_ff      <= pos_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
   end

   assign rs_wide  = (FW + 32)'(rs_ff);
   assign re_wide  = (FW + 32)'(re_ff);
   assign cnt_wide = (CNT_W + 6)'(cnt_ff);

   assign status.idle = (state_ff == S_IDLE);
   assign status.done = (state_ff == S_DONE);

   assign result.found       = found_ff && (cmd_ff == CMD_LOOKUP);
   assign result.range_start = rs_wide[31:0];
   assign result.range_end   = re_wide[31:0];
   assign result.entries_now = cnt_wide[5:0];
   assign result.overflow    = ovf_ff;
endmodule

[design/interval_set_subtract_lookup.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_set_subtract_lookup
// Sorted range table with clear, append, subtract/split and lookup commands.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  req     | req_valid req_stall req_command/frame_* | in
//  rsp     | rsp_valid rsp_stall rsp_found ...       | out
//
// Clear and append finish without walking the table. Subtract walks the table
// from the tail, reading each entry visited, and moves entries one at a time,
// a read and then a write, when a range is erased or split. Lookup is a binary
// search over the table. Reset empties the table at once. A new beat
// is taken only while the sequencer is idle and no result waits.
module interval_set_subtract_lookup #(
   parameter int MAX_RANGES  = 32,
   parameter int FRAME_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_frame_a,
   input  logic [31:0] req_frame_b,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic [31:0] rsp_range_start,
   output logic [31:0] rsp_range_end,
   output logic [5:0]  rsp_entries_now,
   output logic        rsp_overflow
);
   import isl_pkg::*;

   localparam int IDX_W = $clog2(MAX_RANGES);

   status_type status;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       start;

   logic                     mem_wr_en;
   logic [IDX_W-1:0]         mem_wr_addr, mem_rd_addr;
   logic [2*FRAME_WIDTH-1:0] mem_wr_data, mem_rd_data;

   assign req_stall = !status.idle || rsp_valid_ff;
   assign start     = req_valid && !req_stall;

   isl_ctrl #(
      .MAX_RANGES  (MAX_RANGES),
      .FRAME_WIDTH (FRAME_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .cmd         (cmd_type'(req_command)),
      .frame_a     (req_frame_a),
      .frame_b     (req_frame_b),
      .status      (status),
      .result      (result),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   isl_mem #(
      .DEPTH  (MAX_RANGES),
      .DATA_W (2 * FRAME_WIDTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // hold the result beat until the far side takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (status.done) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (status.done) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_ff.found;
   assign rsp_range_start = rsp_ff.range_start;
   assign rsp_range_end   = rsp_ff.range_end;
   assign rsp_entries_now = rsp_ff.entries_now;
   assign rsp_overflow    = rsp_ff.overflow;
endmodule
